// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check themselves.
// No dependencies; clock and reset names follow the house convention.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, ignored while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same check, also evaluated while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/rvd_pkg.sv =====
// Shared types and constants for the RV32IM decoder.
// No dependencies; used by rvd_decode and the top level.
package rvd_pkg;

    localparam int XLEN = 32;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [XLEN-1:0] WORD_ECALL = 32'h0000_0073;

    typedef enum logic [5:0] {
        MN_UNKNOWN, MN_SYSTEM_OTHER, MN_LUI, MN_AUIPC, MN_JAL, MN_JALR,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU,
        MN_SB, MN_SH, MN_SW,
        MN_ADDI, MN_SLTI, MN_SLTIU, MN_XORI, MN_ORI, MN_ANDI,
        MN_SLLI, MN_SRLI, MN_SRAI,
        MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA,
        MN_OR, MN_AND,
        MN_MUL, MN_DIV, MN_DIVU, MN_REM, MN_REMU,
        MN_ECALL
    } t_mnem;

    typedef struct packed {
        logic [XLEN-1:0]   target;
        logic signed [XLEN-1:0] immediate;
        logic [4:0]        shift_amount;
        logic [4:0]        src2_reg;
        logic [4:0]        src1_reg;
        logic [4:0]        dest_reg;
        t_mnem             mnemonic;
    } t_result;

    localparam int RESULT_BITS = $bits(t_result);
    localparam int OUT_BYTES   = (RESULT_BITS + 7) / 8;

endpackage

// ===== rtl/rv32im_instruction_decoder_top.sv =====
// Top level of the RV32IM decoder: input register, decode, result register.
// Depends on rvd_pkg, rvd_decode and assert_macros.svh.
//
// Decodes one RV32IM instruction word per clock, sustained, unless the master
// port stalls. A word taken at the slave port lands in the input register, is
// decoded in the following cycle and moves on to the result register, which
// drives the master port. Each stage advances when the stage after it is empty
// or is being drained, so s_axis_tready follows m_axis_tready combinationally.
// Decoding has no state: every word stands on its own.
`include "assert_macros.svh"

module rv32im_instruction_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] pc, [63:32] word
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] mnemonic, [10:6] dest_reg, [15:11] src1_reg, [20:16] src2_reg,
    // [25:21] shift_amount, [57:26] immediate, [89:58] target, [95:90] zero
    output logic [rvd_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);

    logic                      r_in_vld, n_in_vld;
    logic [rvd_pkg::XLEN-1:0]  r_pc, r_word;
    logic                      r_out_vld, n_out_vld;
    rvd_pkg::t_result          r_res;
    rvd_pkg::t_result          dec_res;
    logic                      out_adv;
    logic                      in_take;

    assign out_adv       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || out_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    rvd_decode u_decode (
        .i_pc     (r_pc),
        .i_word   (r_word),
        .o_result (dec_res)
    );

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        if (out_adv) n_out_vld = r_in_vld;
        if (s_axis_tready) n_in_vld = s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pc   <= s_axis_tdata[31:0];
            r_word <= s_axis_tdata[63:32];
        end
        if (out_adv && r_in_vld) r_res <= dec_res;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(rvd_pkg::OUT_BYTES*8 - rvd_pkg::RESULT_BITS){1'b0}}, r_res};

    `ASSERT_CLK(a_take_fills_in, in_take |=> r_in_vld, "accepted word not held in input register")
    `ASSERT_CLK(a_drain_empties, (r_out_vld && m_axis_tready && !r_in_vld) |=> !r_out_vld, "result repeated after drain")
    `ASSERT_CLK(a_unknown_zero, (m_axis_tvalid && (r_res.mnemonic == rvd_pkg::MN_UNKNOWN)) |-> ((r_res.immediate == '0) && (r_res.target == '0) && (r_res.shift_amount == '0)), "unknown word with nonzero fields")
    `ASSERT_CLK(a_shamt_shift, (m_axis_tvalid && (r_res.shift_amount != '0)) |-> ((r_res.mnemonic == rvd_pkg::MN_SLLI) || (r_res.mnemonic == rvd_pkg::MN_SRLI) || (r_res.mnemonic == rvd_pkg::MN_SRAI)), "shift amount on non-shift")
    `ASSERT_ALWAYS(a_reset_idle, (!$past(i_rst_n)) |-> (!r_in_vld && !r_out_vld), "pipeline not empty after reset")

endmodule

// ===== rtl/rvd_decode.sv =====
// Combinational RV32IM decode: mnemonic, register fields, immediate, target.
// Depends on rvd_pkg.
module rvd_decode (
    input  logic [rvd_pkg::XLEN-1:0] i_pc,
    input  logic [rvd_pkg::XLEN-1:0] i_word,
    output rvd_pkg::t_result         o_result
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    rvd_pkg::t_mnem mn;
    logic [31:0] imm;
    logic        has_tgt;
    logic        is_shift;

    assign opc = i_word[6:0];
    assign f3  = i_word[14:12];
    assign f7  = i_word[31:25];

    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};
    assign imm_u = {i_word[31:12], 12'h000};

    always_comb begin
        mn = rvd_pkg::MN_UNKNOWN;
        unique case (opc)
            rvd_pkg::OPC_LUI:   mn = rvd_pkg::MN_LUI;
            rvd_pkg::OPC_AUIPC: mn = rvd_pkg::MN_AUIPC;
            rvd_pkg::OPC_JAL:   mn = rvd_pkg::MN_JAL;
            rvd_pkg::OPC_JALR: begin
                if (f3 == 3'd0) mn = rvd_pkg::MN_JALR;
            end
            rvd_pkg::OPC_BRANCH: begin
                unique case (f3)
                    3'd0:    mn = rvd_pkg::MN_BEQ;
                    3'd1:    mn = rvd_pkg::MN_BNE;
                    3'd4:    mn = rvd_pkg::MN_BLT;
                    3'd5:    mn = rvd_pkg::MN_BGE;
                    3'd6:    mn = rvd_pkg::MN_BLTU;
                    3'd7:    mn = rvd_pkg::MN_BGEU;
                    default: mn = rvd_pkg::MN_UNKNOWN;
                endcase
            end
            rvd_pkg::OPC_LOAD: begin
                unique case (f3)
                    3'd0:    mn = rvd_pkg::MN_LB;
                    3'd1:    mn = rvd_pkg::MN_LH;
                    3'd2:    mn = rvd_pkg::MN_LW;
                    3'd4:    mn = rvd_pkg::MN_LBU;
                    3'd5:    mn = rvd_pkg::MN_LHU;
                    default: mn = rvd_pkg::MN_UNKNOWN;
                endcase
            end
            rvd_pkg::OPC_STORE: begin
                unique case (f3)
                    3'd0:    mn = rvd_pkg::MN_SB;
                    3'd1:    mn = rvd_pkg::MN_SH;
                    3'd2:    mn = rvd_pkg::MN_SW;
                    default: mn = rvd_pkg::MN_UNKNOWN;
                endcase
            end
            rvd_pkg::OPC_OPIMM: begin
                unique case (f3)
                    3'd0: mn = rvd_pkg::MN_ADDI;
                    3'd1: mn = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_SLLI
                                                        : rvd_pkg::MN_UNKNOWN;
                    3'd2: mn = rvd_pkg::MN_SLTI;
                    3'd3: mn = rvd_pkg::MN_SLTIU;
                    3'd4: mn = rvd_pkg::MN_XORI;
                    3'd5: begin
                        if (f7 == rvd_pkg::F7_BASE)     mn = rvd_pkg::MN_SRLI;
                        else if (f7 == rvd_pkg::F7_ALT) mn = rvd_pkg::MN_SRAI;
                    end
                    3'd6: mn = rvd_pkg::MN_ORI;
                    3'd7: mn = rvd_pkg::MN_ANDI;
                    default: mn = rvd_pkg::MN_UNKNOWN;
                endcase
            end
            rvd_pkg::OPC_OP: begin
                if (f7 == rvd_pkg::F7_BASE) begin
                    unique case (f3)
                        3'd0: mn = rvd_pkg::MN_ADD;
                        3'd1: mn = rvd_pkg::MN_SLL;
                        3'd2: mn = rvd_pkg::MN_SLT;
                        3'd3: mn = rvd_pkg::MN_SLTU;
                        3'd4: mn = rvd_pkg::MN_XOR;
                        3'd5: mn = rvd_pkg::MN_SRL;
                        3'd6: mn = rvd_pkg::MN_OR;
                        3'd7: mn = rvd_pkg::MN_AND;
                        default: mn = rvd_pkg::MN_UNKNOWN;
                    endcase
                end else if (f7 == rvd_pkg::F7_ALT) begin
                    if (f3 == 3'd0)      mn = rvd_pkg::MN_SUB;
                    else if (f3 == 3'd5) mn = rvd_pkg::MN_SRA;
                end else if (f7 == rvd_pkg::F7_MULDIV) begin
                    // mulh, mulhsu and mulhu are left undecoded
                    unique case (f3)
                        3'd0:    mn = rvd_pkg::MN_MUL;
                        3'd4:    mn = rvd_pkg::MN_DIV;
                        3'd5:    mn = rvd_pkg::MN_DIVU;
                        3'd6:    mn = rvd_pkg::MN_REM;
                        3'd7:    mn = rvd_pkg::MN_REMU;
                        default: mn = rvd_pkg::MN_UNKNOWN;
                    endcase
                end
            end
            rvd_pkg::OPC_SYSTEM: begin
                mn = (i_word == rvd_pkg::WORD_ECALL) ? rvd_pkg::MN_ECALL
                                                     : rvd_pkg::MN_SYSTEM_OTHER;
            end
            default: mn = rvd_pkg::MN_UNKNOWN;
        endcase
    end

    // immediate follows the format of the decoded mnemonic, zero if none
    always_comb begin
        imm     = '0;
        has_tgt = 1'b0;
        if (mn != rvd_pkg::MN_UNKNOWN) begin
            unique case (opc)
                rvd_pkg::OPC_LUI, rvd_pkg::OPC_AUIPC: imm = imm_u;
                rvd_pkg::OPC_JAL: begin
                    imm     = imm_j;
                    has_tgt = 1'b1;
                end
                rvd_pkg::OPC_BRANCH: begin
                    imm     = imm_b;
                    has_tgt = 1'b1;
                end
                rvd_pkg::OPC_JALR, rvd_pkg::OPC_LOAD, rvd_pkg::OPC_OPIMM: imm = imm_i;
                rvd_pkg::OPC_STORE: imm = imm_s;
                default: imm = '0;
            endcase
        end
    end

    assign is_shift = (mn == rvd_pkg::MN_SLLI) || (mn == rvd_pkg::MN_SRLI) ||
                      (mn == rvd_pkg::MN_SRAI);

    always_comb begin
        o_result.mnemonic     = mn;
        o_result.dest_reg     = i_word[11:7];
        o_result.src1_reg     = i_word[19:15];
        o_result.src2_reg     = i_word[24:20];
        o_result.shift_amount = is_shift ? i_word[24:20] : 5'd0;
        o_result.immediate    = imm;
        o_result.target       = has_tgt ? (i_pc + imm) : '0;
    end

endmodule
